// ----- design/zrnd_pkg.sv -----
package zrnd_pkg;

   // Width of one run code; the all-ones code is the escape.
   localparam int CODE_BITS = 4;
   localparam int ESCAPE_CODE = (1 << CODE_BITS) - 1;

   // Bits held over between codes (always fewer than one byte).
   localparam int PEND_BITS = 7;
   localparam int PCNT_BITS = 3;

   // Worst case bits in flight for one code: held bits, an escape run and a one bit.
   localparam int MAX_BITS = PEND_BITS + ESCAPE_CODE + 1;
   localparam int MAX_BYTES = (MAX_BITS + 7) / 8;
   localparam int WIN_BITS = 8 * MAX_BYTES;
   localparam int TOTAL_W = $clog2(WIN_BITS + 1);
   localparam int CNT_W = $clog2(MAX_BYTES + 1);

   // Job queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 final_code;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_stream;
   } rsp_type;

   // One decoded code as the back sees it: a window of bits, MSB first,
   // the number of results it yields, and how the stream closes.
   typedef struct packed {
      logic [WIN_BITS-1:0] window;
      logic [CNT_W-1:0]    count;
      logic                close;
      logic                marker;
   } job_type;

   // Queue handshake between the front and the queue.
   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

endpackage

// ----- design/zrnd_front.sv -----
module zrnd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  zrnd_pkg::req_type req_payload,
   input  logic             queue_full,
   output zrnd_pkg::push_type push_out
);
   import zrnd_pkg::*;

   logic [PEND_BITS-1:0] pend_bits_ff, pend_bits_in;
   logic [PCNT_BITS-1:0] pend_count_ff, pend_count_in;

   logic                accept;
   logic                one_bit;
   logic [TOTAL_W-1:0]  total;
   logic [CNT_W-1:0]    full_bytes;
   logic [2:0]          rem;
   logic [WIN_BITS-1:0] window;
   logic [WIN_BITS-1:0] rest;
   logic [7:0]          head_byte;
   logic [CNT_W-1:0]    count;

   assign req_stall = queue_full;
   assign accept = req_valid && !req_stall;

   always_comb begin
      one_bit = (req_payload.code != CODE_BITS'(ESCAPE_CODE)) && !req_payload.final_code;
      total = TOTAL_W'(pend_count_ff) + TOTAL_W'(req_payload.code) + TOTAL_W'(one_bit);
      full_bytes = CNT_W'(total >> 3);
      rem = total[2:0];

      // Held bits go to the top of the window, the run of zeros follows,
      // then the closing one bit if there is one.
      window = {pend_bits_ff, {(WIN_BITS - PEND_BITS){1'b0}}}
               << (PEND_BITS - int'(pend_count_ff));
      if (one_bit) begin
         window = window | ({1'b1, {(WIN_BITS - 1){1'b0}}}
                  >> (TOTAL_W'(pend_count_ff) + TOTAL_W'(req_payload.code)));
      end

      rest = window << (8 * int'(full_bytes));
      head_byte = rest[WIN_BITS-1 -: 8];

      if (!req_payload.final_code) begin
         count = full_bytes;
      end else if (rem != 3'd0) begin
         count = full_bytes + CNT_W'(1);
      end else if (full_bytes == '0) begin
         count = CNT_W'(1);
      end else begin
         count = full_bytes;
      end
   end

   always_comb begin
      pend_bits_in = pend_bits_ff;
      pend_count_in = pend_count_ff;
      if (accept) begin
         if (req_payload.final_code) begin
            pend_bits_in = '0;
            pend_count_in = '0;
         end else begin
            pend_bits_in = PEND_BITS'(head_byte >> (4'd8 - {1'b0, rem}));
            pend_count_in = rem;
         end
      end
   end

   always_comb begin
      push_out.push = accept && (count != '0);
      push_out.job.window = window;
      push_out.job.count = count;
      push_out.job.close = req_payload.final_code;
      push_out.job.marker = req_payload.final_code && (full_bytes == '0) && (rem == 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_count_ff <= '0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_count_ff <= pend_count_in;
      end
   end

endmodule

// ----- design/zrnd_queue.sv -----
module zrnd_queue (
   input  logic               clock,
   input  logic               reset,
   input  zrnd_pkg::push_type push_in,
   output logic               full,
   output logic               head_valid,
   output zrnd_pkg::job_type  head_job,
   input  logic               pop
);
   import zrnd_pkg::*;

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   logic                do_push;
   logic                do_pop;

   assign full = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push = push_in.push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_in.job;
      end
   end

endmodule

// ----- design/zrnd_back.sv -----
module zrnd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  zrnd_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output zrnd_pkg::rsp_type rsp_payload
);
   import zrnd_pkg::*;

   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                load;
   logic                take;
   logic                last_piece;
   logic [WIN_BITS-1:0] shifted;

   assign load = !rsp_valid_ff || !rsp_stall;
   assign take = load && head_valid;
   assign last_piece = (idx_ff == head_job.count - CNT_W'(1));
   assign pop = take && last_piece;

   always_comb begin
      shifted = head_job.window << (8 * int'(idx_ff));
      rsp_in.data_byte = shifted[WIN_BITS-1 -: 8];
      rsp_in.byte_valid = !head_job.marker;
      rsp_in.end_of_stream = head_job.close && last_piece;

      rsp_valid_in = load ? head_valid : rsp_valid_ff;

      idx_in = idx_ff;
      if (take) begin
         idx_in = last_piece ? '0 : idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- design/zero_run_nibble_decoder.sv -----
// Path: a code's first byte goes through the job queue and then the output register.
// Throughput: one code per cycle in while the queue has room; one result per cycle out
// of the output register while rsp_stall is low. A code yields up to three results.
// Reset: synchronous, active high; clears the held partial byte, the job queue and the
// output valid, so a new stream starts empty.
module zero_run_nibble_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  zrnd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output zrnd_pkg::rsp_type rsp_payload
);
   import zrnd_pkg::*;

   // The front turns codes that yield results into jobs: a window of decoded bits,
   // the number of bytes to send and how the stream closes. It also keeps the partial byte.
   push_type push;
   logic     queue_full;

   // The queue lets the front keep taking codes while the back drains bytes.
   logic     head_valid;
   job_type  head_job;
   logic     pop;

   zrnd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push_out    (push)
   );

   zrnd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   // The back sends one byte per transfer and retires a job after its last byte.
   zrnd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- verif/decode_checker.sv -----
module decode_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  zrnd_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  zrnd_pkg::rsp_type rsp_payload,
   output int                mismatch_count,
   output int                expected_left,
   output int                results_seen,
   output int                markers_seen
);
   import zrnd_pkg::*;

   localparam int PRINT_CAP = 40;

   // Predicted decoder state: the partial byte, right aligned, and its fill.
   logic [PEND_BITS-1:0] held_bits = '0;
   logic [PCNT_BITS-1:0] held_count = '0;
   int                   step_results;
   rsp_type              expected_bytes[$];
   rsp_type              want;

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // Shift one decoded bit into the partial byte; a full byte becomes a result.
   function automatic void append_bit(input logic b);
      logic [7:0] acc;
      rsp_type    r;
      acc = {held_bits, b};
      if (held_count == PCNT_BITS'(7)) begin
         r.data_byte = acc;
         r.byte_valid = 1'b1;
         r.end_of_stream = 1'b0;
         expected_bytes.push_back(r);
         held_bits = '0;
         held_count = '0;
         step_results++;
      end else begin
         held_bits = acc[PEND_BITS-1:0];
         held_count = held_count + 1'b1;
      end
   endfunction

   function automatic void decode_code(input req_type r);
      rsp_type closing;
      step_results = 0;
      for (int i = 0; i < int'(r.code); i++) begin
         append_bit(1'b0);
      end
      if (r.code != CODE_BITS'(ESCAPE_CODE) && !r.final_code) begin
         append_bit(1'b1);
      end
      if (r.final_code) begin
         if (held_count != '0) begin
            // The partial byte is flushed, padded with zeros at its low end.
            closing.data_byte = 8'({1'b0, held_bits} << (8 - int'(held_count)));
            closing.byte_valid = 1'b1;
            closing.end_of_stream = 1'b1;
         end else if (step_results > 0) begin
            // The last byte of this code closes the stream.
            closing = expected_bytes[expected_bytes.size() - 1];
            expected_bytes.delete(expected_bytes.size() - 1);
            closing.end_of_stream = 1'b1;
         end else begin
            closing.data_byte = 8'h00;
            closing.byte_valid = 1'b0;
            closing.end_of_stream = 1'b1;
         end
         expected_bytes.push_back(closing);
         held_bits = '0;
         held_count = '0;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_bits = '0;
         held_count = '0;
         expected_bytes.delete();
      end else begin
         // A result can never stem from a code taken at the same edge, so the
         // comparison goes first.
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (!rsp_payload.byte_valid) begin
               markers_seen++;
            end
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("result %h arrived with none expected",
                                         rsp_payload));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_payload.data_byte !== want.data_byte) begin
                  report_mismatch($sformatf("data_byte %h, expected %h",
                                            rsp_payload.data_byte, want.data_byte));
               end
               if (rsp_payload.byte_valid !== want.byte_valid) begin
                  report_mismatch($sformatf("byte_valid %b, expected %b",
                                            rsp_payload.byte_valid, want.byte_valid));
               end
               if (rsp_payload.end_of_stream !== want.end_of_stream) begin
                  report_mismatch($sformatf("end_of_stream %b, expected %b",
                                            rsp_payload.end_of_stream,
                                            want.end_of_stream));
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_code(req_payload);
         end
      end
      expected_left = expected_bytes.size();
   end

endmodule

// ----- verif/tb.sv -----
module tb;

   import zrnd_pkg::*;

   // Run length and pacing.
   localparam int ITEM_TARGET = 170;
   localparam int CALM_ITEMS = 25;
   localparam int SQUEEZE_AT = 70;
   localparam int SQUEEZE_CODES = 12;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 100000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   int mismatch_count;
   int expected_left;
   int results_seen;
   int markers_seen;

   int codes_sent = 0;
   int streams_sent = 0;
   int cycle_count = 0;

   // Pacing controls for the sender and the receiver. When calm is set,
   // neither side idles any more. Each increment of squeeze_asked asks the
   // receiver for one long hold-off.
   bit calm = 1'b0;
   bit gaps_on = 1'b0;
   int squeeze_asked = 0;

   zero_run_nibble_decoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   decode_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .expected_left  (expected_left),
      .results_seen   (results_seen),
      .markers_seen   (markers_seen)
   );

   initial begin
      forever begin
         #2 clock = ~clock;
      end
   end

   // The run is ended here if the decoder hangs or loses a result.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: stall comes in bursts of random length, with stall chosen for
   // only a third of the bursts so that free-running stretches occur too. A
   // squeeze request holds stall high until hold_left, loaded from HOLD_CYCLES,
   // runs out, so that the decoder's job queue fills and it stalls its input.
   int stall_left = 0;
   int hold_left = 0;
   int squeeze_seen = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (squeeze_asked != squeeze_seen) begin
         squeeze_seen = squeeze_asked;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   // Offers one code at a falling edge and holds it until the transfer takes
   // place. Afterwards the sender may idle for a random gap. The valid is only
   // lowered for such a gap, so it is never lowered and raised in the same
   // time step.
   task automatic send_code(input logic [CODE_BITS-1:0] c, input logic is_last);
      req_valid <= 1'b1;
      req_payload <= '{code: c, final_code: is_last};
      do begin
         @(posedge clock);
      end while (req_stall);
      codes_sent++;
      if (is_last) begin
         streams_sent++;
      end
      @(negedge clock);
      if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   // Escape codes and very short runs are favored: escapes build long zero
   // runs across byte boundaries, short runs pack many one bits into a byte.
   function automatic logic [CODE_BITS-1:0] pick_code();
      case ($urandom_range(0, 3))
         0: begin
            return CODE_BITS'(ESCAPE_CODE);
         end
         1: begin
            return CODE_BITS'($urandom_range(0, 2));
         end
         default: begin
            return CODE_BITS'($urandom_range(0, ESCAPE_CODE));
         end
      endcase
   endfunction

   initial begin
      int  stream_len;
      bit  squeezed;
      squeezed = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, no sender gaps. A lone final zero code closes an empty
      // stream with an end marker.
      send_code(4'd0, 1'b1);
      // Seven zeros and a one fill exactly one byte; the next final code then
      // has nothing to flush and emits no data byte, so it sends an end marker.
      send_code(4'd7, 1'b0);
      send_code(4'd0, 1'b1);
      // A final code that completes a byte and leaves nothing over marks that
      // byte as the end of the stream.
      send_code(4'd8, 1'b1);
      // A chain of escapes and a long run, closed by a final escape: the last
      // code yields two full bytes plus the padded partial byte.
      send_code(CODE_BITS'(ESCAPE_CODE), 1'b0);
      send_code(CODE_BITS'(ESCAPE_CODE), 1'b0);
      send_code(4'd14, 1'b0);
      send_code(CODE_BITS'(ESCAPE_CODE), 1'b1);
      // A short final run leaves a partial byte that is padded at its low end.
      send_code(4'd3, 1'b1);
      // Eight zero-length runs give an all-ones byte.
      repeat (8) send_code(4'd0, 1'b0);
      send_code(4'd0, 1'b1);
      // A final escape on an empty stream: one byte plus a padded byte.
      send_code(CODE_BITS'(ESCAPE_CODE), 1'b1);
      send_code(4'd1, 1'b0);
      send_code(4'd2, 1'b0);
      send_code(4'd14, 1'b1);

      // Random part: mostly well-formed streams of one to eight codes with
      // random content, the rest single codes with a random final flag.
      while (codes_sent < ITEM_TARGET) begin
         if (codes_sent >= ITEM_TARGET - CALM_ITEMS) begin
            calm = 1'b1;
         end
         if (!squeezed && codes_sent >= SQUEEZE_AT) begin
            // The receiver holds off while codes keep coming back to back.
            squeezed = 1'b1;
            squeeze_asked++;
            gaps_on = 1'b0;
            repeat (SQUEEZE_CODES - 1) send_code(pick_code(), 1'b0);
            send_code(pick_code(), 1'b1);
         end
         gaps_on = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 6) == 0) begin
            send_code(pick_code(), 1'($urandom_range(0, 1)));
         end else begin
            stream_len = $urandom_range(1, 8);
            for (int k = 0; k < stream_len; k++) begin
               send_code(pick_code(), k == stream_len - 1);
            end
         end
      end
      req_valid <= 1'b0;

      // Drain: wait until every predicted result has arrived, then keep running
      // so that the decoder can show any stray result.
      do begin
         @(negedge clock);
      end while (expected_left != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d codes closing %0d streams, with gaps and stalls of both sides.",
               codes_sent, streams_sent);
      $display("Checked %0d results, %0d of them end markers; %0d mismatches.",
               results_seen, markers_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
